/* sv/knob_menu_settings_editor_macros.svh */
// assertion helpers included by kmse_core
`ifndef KNOB_MENU_SETTINGS_EDITOR_MACROS_SVH
`define KNOB_MENU_SETTINGS_EDITOR_MACROS_SVH

// condition must hold at every edge out of reset
`define KMSE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define KMSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define KMSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/kmse_pkg.sv */
package kmse_pkg;

    // menu size limit
    localparam int MAX_ITEMS = 16;
    localparam int ITEM_CAP  = (MAX_ITEMS < 16) ? MAX_ITEMS : 16;

    // config bus
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 3'd0;
    localparam logic [IDX_W-1:0] REG_ITEM_COUNT = 3'd1;
    localparam logic [IDX_W-1:0] REG_INIT_MIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_INIT_MAX   = 3'd3;
    localparam logic [IDX_W-1:0] REG_INIT_MODE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_INIT_DELAY = 3'd5;
    localparam logic [IDX_W-1:0] REG_INIT_HUM   = 3'd6;

    // register reset values
    localparam logic [15:0]       RST_LONG_PRESS = 16'd5000;
    localparam logic [4:0]        RST_ITEM_COUNT = 5'd7;
    localparam logic signed [7:0] RST_MIN_TEMP   = 8'sd20;
    localparam logic signed [7:0] RST_MAX_TEMP   = 8'sd30;
    localparam logic [2:0]        RST_OP_MODE    = 3'd0;
    localparam logic [8:0]        RST_DELAY      = 9'd10;
    localparam logic [6:0]        RST_HUM        = 7'd60;

    // menu items
    localparam logic [3:0] ITEM_BACK      = 4'd0;
    localparam logic [3:0] ITEM_MIN_TEMP  = 4'd1;
    localparam logic [3:0] ITEM_MAX_TEMP  = 4'd2;
    localparam logic [3:0] ITEM_OP_MODE   = 4'd3;
    localparam logic [3:0] ITEM_DELAY     = 4'd4;
    localparam logic [3:0] ITEM_HUM       = 4'd5;
    localparam logic [3:0] ITEM_RECONNECT = 4'd6;

    // setting limits
    localparam logic [3:0]         MODE_COUNT = 4'd5;
    localparam logic signed [10:0] DELAY_LO   = 11'sd1;
    localparam logic signed [10:0] DELAY_HI   = 11'sd300;
    localparam logic signed [8:0]  HUM_HI     = 9'sd100;
    localparam logic [15:0]        HOLD_MAX   = 16'hFFFF;

    typedef struct packed {
        logic enc_a;
        logic enc_b;
        logic button_level;
    } in_word_t;

    typedef struct packed {
        logic              in_settings;
        logic              editing;
        logic [3:0]        selected_item;
        logic signed [7:0] min_temp;
        logic signed [7:0] max_temp;
        logic [2:0]        op_mode;
        logic [8:0]        switch_delay;
        logic [6:0]        hum_limit;
        logic              beep;
        logic              save_request;
        logic              reconnect_request;
        logic              restart_request;
    } out_word_t;

    typedef struct packed {
        logic [15:0] long_press_ticks;
        logic [4:0]  item_count;
    } cfg_t;

    // direct setting loads from init register writes
    typedef struct packed {
        logic       min_wr;
        logic       max_wr;
        logic       mode_wr;
        logic       delay_wr;
        logic       hum_wr;
        logic [8:0] data;
    } load_t;

endpackage

/* sv/kmse_regs.sv */
module kmse_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kmse_pkg::ADDR_W-1:0] paddr,
    input  logic [kmse_pkg::DATA_W-1:0] pwdata,
    output logic [kmse_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output kmse_pkg::cfg_t              cfg,
    output kmse_pkg::load_t             load
);
    import kmse_pkg::*;

    logic [15:0]       long_press_reg, long_press_next;
    logic [4:0]        item_count_reg, item_count_next;
    logic [7:0]        init_min_reg, init_min_next;
    logic [7:0]        init_max_reg, init_max_next;
    logic [2:0]        init_mode_reg, init_mode_next;
    logic [8:0]        init_delay_reg, init_delay_next;
    logic [6:0]        init_hum_reg, init_hum_next;
    logic              wr_en;
    logic [IDX_W-1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[IDX_W+1:2];

    always_comb
    begin
        long_press_next = long_press_reg;
        item_count_next = item_count_reg;
        init_min_next   = init_min_reg;
        init_max_next   = init_max_reg;
        init_mode_next  = init_mode_reg;
        init_delay_next = init_delay_reg;
        init_hum_next   = init_hum_reg;
        load            = '0;
        load.data       = pwdata[8:0];
        if (wr_en)
        begin
            case (idx)
                REG_LONG_PRESS: long_press_next = pwdata[15:0];
                REG_ITEM_COUNT: item_count_next = pwdata[4:0];
                REG_INIT_MIN:
                begin
                    init_min_next = pwdata[7:0];
                    load.min_wr   = 1'b1;
                end
                REG_INIT_MAX:
                begin
                    init_max_next = pwdata[7:0];
                    load.max_wr   = 1'b1;
                end
                REG_INIT_MODE:
                begin
                    init_mode_next = pwdata[2:0];
                    load.mode_wr   = 1'b1;
                end
                REG_INIT_DELAY:
                begin
                    init_delay_next = pwdata[8:0];
                    load.delay_wr   = 1'b1;
                end
                REG_INIT_HUM:
                begin
                    init_hum_next = pwdata[6:0];
                    load.hum_wr   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= RST_LONG_PRESS;
            item_count_reg <= RST_ITEM_COUNT;
            init_min_reg   <= RST_MIN_TEMP;
            init_max_reg   <= RST_MAX_TEMP;
            init_mode_reg  <= RST_OP_MODE;
            init_delay_reg <= RST_DELAY;
            init_hum_reg   <= RST_HUM;
        end
        else
        begin
            long_press_reg <= long_press_next;
            item_count_reg <= item_count_next;
            init_min_reg   <= init_min_next;
            init_max_reg   <= init_max_next;
            init_mode_reg  <= init_mode_next;
            init_delay_reg <= init_delay_next;
            init_hum_reg   <= init_hum_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_LONG_PRESS: prdata = DATA_W'(long_press_reg);
            REG_ITEM_COUNT: prdata = DATA_W'(item_count_reg);
            REG_INIT_MIN:   prdata = DATA_W'(init_min_reg);
            REG_INIT_MAX:   prdata = DATA_W'(init_max_reg);
            REG_INIT_MODE:  prdata = DATA_W'(init_mode_reg);
            REG_INIT_DELAY: prdata = DATA_W'(init_delay_reg);
            REG_INIT_HUM:   prdata = DATA_W'(init_hum_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.long_press_ticks = long_press_reg;
    assign cfg.item_count       = item_count_reg;

endmodule

/* sv/kmse_core.sv */
`include "knob_menu_settings_editor_macros.svh"

module kmse_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  kmse_pkg::in_word_t  sample,
    input  kmse_pkg::cfg_t      cfg,
    input  kmse_pkg::load_t     load,
    output kmse_pkg::out_word_t result_next
);
    import kmse_pkg::*;

    logic              prev_a_reg, prev_a_next;
    logic              prev_button_reg, prev_button_next;
    logic [15:0]       hold_count_reg, hold_count_next;
    logic              long_fired_reg, long_fired_next;
    logic              settings_shown_reg, settings_shown_next;
    logic              edit_active_reg, edit_active_next;
    logic [3:0]        item_index_reg, item_index_next;
    logic signed [7:0] min_temp_reg, min_temp_next;
    logic signed [7:0] max_temp_reg, max_temp_next;
    logic [2:0]        op_mode_reg, op_mode_next;
    logic [8:0]        delay_reg, delay_next;
    logic [6:0]        hum_reg, hum_next;

    logic               rise_a;
    logic               up;
    logic signed [9:0]  min_sum, max_sum;
    logic signed [7:0]  min_sat, max_sat, min_new, max_new;
    logic [3:0]         mode_raw;
    logic [2:0]         mode_new;
    logic signed [10:0] delay_sum;
    logic [8:0]         delay_new;
    logic signed [8:0]  hum_sum;
    logic [6:0]         hum_new;
    logic [4:0]         lim, lim_m1;
    logic [3:0]         item_hi;
    logic signed [5:0]  item_sum;
    logic [3:0]         item_new;
    logic               press, release_evt, fire;
    logic [15:0]        hold_mid;
    logic               fired_mid;

    // candidate values for one encoder step
    always_comb
    begin
        rise_a = !prev_a_reg && sample.enc_a;
        up     = !sample.enc_b;

        min_sum = $signed({min_temp_reg[7], min_temp_reg[7], min_temp_reg})
                  + (up ? 10'sd1 : -10'sd1);
        if (min_sum > 10'sd127)
            min_sat = 8'sd127;
        else if (min_sum < -10'sd128)
            min_sat = -8'sd128;
        else
            min_sat = min_sum[7:0];
        min_new = (min_sat > max_temp_reg) ? max_temp_reg : min_sat;

        max_sum = $signed({max_temp_reg[7], max_temp_reg[7], max_temp_reg})
                  + (up ? 10'sd1 : -10'sd1);
        if (max_sum > 10'sd127)
            max_sat = 8'sd127;
        else if (max_sum < -10'sd128)
            max_sat = -8'sd128;
        else
            max_sat = max_sum[7:0];
        max_new = (max_sat < min_temp_reg) ? min_temp_reg : max_sat;

        // wrap modulo five, also for out-of-range loaded codes
        if (up)
            mode_raw = {1'b0, op_mode_reg} + 4'd1;
        else if (op_mode_reg == 3'd0)
            mode_raw = MODE_COUNT;
        else
            mode_raw = {1'b0, op_mode_reg} - 4'd1;
        if (!up && op_mode_reg == 3'd0)
            mode_new = 3'(MODE_COUNT - 4'd1);
        else if (mode_raw >= MODE_COUNT)
            mode_new = 3'(mode_raw - MODE_COUNT);
        else
            mode_new = mode_raw[2:0];

        delay_sum = $signed({2'b00, delay_reg}) + (up ? 11'sd1 : -11'sd1);
        if (delay_sum < DELAY_LO)
            delay_new = 9'(DELAY_LO);
        else if (delay_sum > DELAY_HI)
            delay_new = 9'(DELAY_HI);
        else
            delay_new = delay_sum[8:0];

        hum_sum = $signed({2'b00, hum_reg}) + (up ? 9'sd1 : -9'sd1);
        if (hum_sum < 9'sd0)
            hum_new = 7'd0;
        else if (hum_sum > HUM_HI)
            hum_new = 7'(HUM_HI);
        else
            hum_new = hum_sum[6:0];

        if (cfg.item_count == 5'd0)
            lim = 5'd1;
        else if (cfg.item_count > 5'(ITEM_CAP))
            lim = 5'(ITEM_CAP);
        else
            lim = cfg.item_count;
        lim_m1  = lim - 5'd1;
        item_hi = lim_m1[3:0];
        item_sum = $signed({2'b00, item_index_reg}) + (up ? 6'sd1 : -6'sd1);
        if (item_sum < 6'sd0)
            item_new = 4'd0;
        else if (item_sum > $signed({2'b00, item_hi}))
            item_new = item_hi;
        else
            item_new = item_sum[3:0];
    end

    // state update: encoder first, then button; init register loads apply only when not stepping
    always_comb
    begin
        prev_a_next         = prev_a_reg;
        prev_button_next    = prev_button_reg;
        hold_count_next     = hold_count_reg;
        long_fired_next     = long_fired_reg;
        settings_shown_next = settings_shown_reg;
        edit_active_next    = edit_active_reg;
        item_index_next     = item_index_reg;
        min_temp_next       = min_temp_reg;
        max_temp_next       = max_temp_reg;
        op_mode_next        = op_mode_reg;
        delay_next          = delay_reg;
        hum_next            = hum_reg;
        result_next         = '0;

        press       = prev_button_reg && !sample.button_level;
        release_evt = !prev_button_reg && sample.button_level;
        if (press)
            hold_mid = '0;
        else if (!sample.button_level && hold_count_reg != HOLD_MAX)
            hold_mid = hold_count_reg + 16'd1;
        else
            hold_mid = hold_count_reg;
        fired_mid = press ? 1'b0 : long_fired_reg;
        fire = !sample.button_level && !fired_mid && (hold_mid >= cfg.long_press_ticks);

        if (step)
        begin
            if (rise_a)
            begin
                if (settings_shown_reg && edit_active_reg)
                begin
                    case (item_index_reg)
                        ITEM_MIN_TEMP: min_temp_next = min_new;
                        ITEM_MAX_TEMP: max_temp_next = max_new;
                        ITEM_OP_MODE:  op_mode_next  = mode_new;
                        ITEM_DELAY:    delay_next    = delay_new;
                        ITEM_HUM:      hum_next      = hum_new;
                        default: ;
                    endcase
                end
                else if (settings_shown_reg)
                begin
                    item_index_next  = item_new;
                    result_next.beep = 1'b1;
                end
            end
            prev_a_next = sample.enc_a;

            hold_count_next = hold_mid;
            long_fired_next = fired_mid | fire;
            if (fire)
            begin
                result_next.restart_request = 1'b1;
                result_next.beep            = 1'b1;
            end

            if (release_evt)
            begin
                if (!fired_mid)
                begin
                    result_next.beep = 1'b1;
                    if (!settings_shown_reg)
                    begin
                        settings_shown_next = 1'b1;
                        edit_active_next    = 1'b0;
                        item_index_next     = ITEM_BACK;
                    end
                    else if (!edit_active_reg)
                    begin
                        if (item_index_next == ITEM_BACK)
                        begin
                            settings_shown_next      = 1'b0;
                            result_next.save_request = 1'b1;
                        end
                        else if (item_index_next == ITEM_RECONNECT)
                        begin
                            settings_shown_next           = 1'b0;
                            result_next.reconnect_request = 1'b1;
                        end
                        else
                            edit_active_next = 1'b1;
                    end
                    else
                    begin
                        edit_active_next         = 1'b0;
                        result_next.save_request = 1'b1;
                    end
                end
                hold_count_next = '0;
            end
            prev_button_next = sample.button_level;
        end
        else
        begin
            if (load.min_wr)
                min_temp_next = load.data[7:0];
            if (load.max_wr)
                max_temp_next = load.data[7:0];
            if (load.mode_wr)
                op_mode_next = load.data[2:0];
            if (load.delay_wr)
                delay_next = load.data;
            if (load.hum_wr)
                hum_next = load.data[6:0];
        end

        result_next.in_settings   = settings_shown_next;
        result_next.editing       = edit_active_next;
        result_next.selected_item = item_index_next;
        result_next.min_temp      = min_temp_next;
        result_next.max_temp      = max_temp_next;
        result_next.op_mode       = op_mode_next;
        result_next.switch_delay  = delay_next;
        result_next.hum_limit     = hum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg         <= 1'b1;
            prev_button_reg    <= 1'b1;
            hold_count_reg     <= '0;
            long_fired_reg     <= 1'b0;
            settings_shown_reg <= 1'b0;
            edit_active_reg    <= 1'b0;
            item_index_reg     <= ITEM_BACK;
            min_temp_reg       <= RST_MIN_TEMP;
            max_temp_reg       <= RST_MAX_TEMP;
            op_mode_reg        <= RST_OP_MODE;
            delay_reg          <= RST_DELAY;
            hum_reg            <= RST_HUM;
        end
        else
        begin
            prev_a_reg         <= prev_a_next;
            prev_button_reg    <= prev_button_next;
            hold_count_reg     <= hold_count_next;
            long_fired_reg     <= long_fired_next;
            settings_shown_reg <= settings_shown_next;
            edit_active_reg    <= edit_active_next;
            item_index_reg     <= item_index_next;
            min_temp_reg       <= min_temp_next;
            max_temp_reg       <= max_temp_next;
            op_mode_reg        <= op_mode_next;
            delay_reg          <= delay_next;
            hum_reg            <= hum_next;
        end
    end

    `KMSE_ASSERT_ALWAYS(a_edit_only_in_menu, clk, rst_n, !edit_active_reg || settings_shown_reg)
    `KMSE_ASSERT_IMPL(a_save_not_with_reconnect, clk, rst_n, step, !(result_next.save_request && result_next.reconnect_request))
    `KMSE_ASSERT_NEXT(a_restart_sets_fired, clk, rst_n, step && result_next.restart_request, long_fired_reg)
    `KMSE_ASSERT_NEXT(a_idle_holds_selector, clk, rst_n, !step, $stable(item_index_reg) && $stable(hold_count_reg))

endmodule

/* sv/knob_menu_settings_editor.sv */
// channel   dir  handshake                        payload
// sample    in   sample_valid / sample_ready      in_word_t: enc_a, enc_b, button_level
// result    out  result_valid / result_ready      out_word_t: menu state, settings, pulses
// config    in   psel/penable/pwrite, pready = 1  paddr, pwdata, prdata (7 regs at 4*i)
//
// one word per cycle sustained while the result is not stalled; a taken sample first lands in the input register
// the input register feeds the update logic, whose output lands in the result register
// a stalled result holds the pipe, but the input register still takes one more word
// rst_n clears the handshake and the menu state; settings and init registers return to the same reset values
// an init register write loads its setting at once, but only in a cycle with no step (else the load is dropped)
module knob_menu_settings_editor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  kmse_pkg::in_word_t          sample,
    output logic                        result_valid,
    input  logic                        result_ready,
    output kmse_pkg::out_word_t         result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kmse_pkg::ADDR_W-1:0] paddr,
    input  logic [kmse_pkg::DATA_W-1:0] pwdata,
    output logic [kmse_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import kmse_pkg::*;

    // input stage
    logic      in_valid_reg, in_valid_next;
    in_word_t  in_word_reg;

    // result stage
    logic      out_valid_reg, out_valid_next;
    out_word_t result_reg;

    out_word_t result_next;
    cfg_t      cfg;
    load_t     load;
    logic      advance;
    logic      step;
    logic      take;

    // result stage can move when empty or being drained
    assign advance      = !out_valid_reg || result_ready;
    assign sample_ready = !in_valid_reg || advance;
    assign take         = sample_valid && sample_ready;
    // a word in the input stage is processed and its state committed
    assign step         = in_valid_reg && advance;

    always_comb
    begin
        if (take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take)
            in_word_reg <= sample;
        if (step)
            result_reg <= result_next;
    end

    kmse_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .load    (load)
    );

    // menu state and settings update
    kmse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .sample      (in_word_reg),
        .cfg         (cfg),
        .load        (load),
        .result_next (result_next)
    );

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule
